### src/assert_macros.svh
// Assertion helpers; clock and reset are taken from the scope of use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only outside reset.
`define MMIO_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Checked on every edge, reset included.
`define MMIO_ASSERT_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);

`endif

### src/mmio_pkg.sv
package mmio_pkg;

   localparam int unsigned RAM_DEPTH_DEF = 65536;
   localparam int unsigned ROM_DEPTH_DEF = 32768;
   localparam int unsigned KEY_ROWS_DEF  = 16;

   localparam int unsigned REQ_TDATA_W = 56;
   localparam int unsigned RSP_TDATA_W = 56;
   localparam int unsigned CSR_IDX_W   = 1;
   localparam int unsigned CSR_DATA_W  = 16;

   localparam logic [2:0] CMD_READ     = 3'd0;
   localparam logic [2:0] CMD_WRITE    = 3'd1;
   localparam logic [2:0] CMD_KEY_ROW  = 3'd2;
   localparam logic [2:0] CMD_BREAK    = 3'd3;
   localparam logic [2:0] CMD_ROM_LOAD = 3'd4;

   localparam logic [CSR_IDX_W-1:0] CSR_RAM_TOP      = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_COLOUR_BOARD = 1'b1;

   localparam logic [15:0] ADDR_BANK0_LO  = 16'hb000;
   localparam logic [15:0] ADDR_BANK0_HI  = 16'hdfff;
   localparam logic [15:0] ADDR_BANK1_LO  = 16'he000;
   localparam logic [15:0] ADDR_BANK1_HI  = 16'he7ff;
   localparam logic [15:0] ADDR_IO_LO     = 16'he800;
   localparam logic [15:0] ADDR_IO_HI     = 16'hefff;
   localparam logic [15:0] ADDR_BANK2_LO  = 16'hf000;
   localparam logic [15:0] ADDR_BANK2_HI  = 16'hffff;
   localparam logic [15:0] ADDR_COLOUR_LO = 16'h0100;
   localparam logic [15:0] ADDR_COLOUR_HI = 16'h03ff;

   localparam logic [15:0] IO_FOREGROUND = 16'he890;
   localparam logic [15:0] IO_BACKGROUND = 16'he891;
   localparam logic [15:0] IO_COLOUR_WE  = 16'he892;
   localparam logic [15:0] IO_TAPE_STOP  = 16'hee00;
   localparam logic [15:0] IO_TAPE_START = 16'hee20;
   localparam logic [15:0] IO_REVERSE    = 16'hee40;
   localparam logic [15:0] IO_TAPE       = 16'hee80;
   localparam logic [15:0] IO_KEY        = 16'heec0;
   localparam logic [15:0] IO_ID_FF      = 16'hef00;
   localparam logic [15:0] IO_ID_80      = 16'hef80;
   localparam logic [15:0] IO_BANK       = 16'hefd0;
   localparam logic [15:0] IO_MODE       = 16'hefe0;

   localparam logic [2:0] BANK_NONE = 3'b000;
   localparam logic [2:0] BANK_B000 = 3'b001;
   localparam logic [2:0] BANK_E000 = 3'b010;
   localparam logic [2:0] BANK_F000 = 3'b100;

   localparam logic [7:0] MODE_MASK = 8'hcc;

   typedef struct packed {
      logic [2:0]  command;
      logic [15:0] address;
      logic [7:0]  write_data;
      logic [7:0]  tape_in_level;
      logic [3:0]  key_row_index;
      logic [7:0]  key_row_bits;
      logic [7:0]  key_modifiers;
   } bus_req_type;

   typedef struct packed {
      logic        en;
      logic        we;
      logic [15:0] addr;
      logic [7:0]  wdata;
   } mem_acc_type;

   typedef struct packed {
      logic       is_mem;
      logic       sel_rom;
      logic [7:0] io_byte;
      logic       tape_stop;
      logic       tape_start;
      logic       tape_out_valid;
      logic [7:0] tape_out_data;
      logic       nmi_request;
      logic       colour_write_valid;
      logic [9:0] colour_index;
      logic [7:0] colour_value;
      logic       reverse_video;
      logic [7:0] gfx_mode;
      logic [7:0] background_colour;
   } stage_type;

endpackage

### src/mmio_ram.sv
module mmio_ram #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     en,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         if (we) begin
            mem[addr] <= wdata;
         end else begin
            rdata_ff <= mem[addr];
         end
      end
   end

   assign rdata = rdata_ff;

endmodule

### src/mmio_ctrl.sv
module mmio_ctrl import mmio_pkg::*; #(
   parameter int unsigned KEY_ROWS = KEY_ROWS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_wr,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data,
   input  logic                  accept,
   input  bus_req_type           req,
   output mem_acc_type           ram_acc,
   output mem_acc_type           rom_acc,
   output stage_type             stage
);

   localparam int unsigned KEY_AW = $clog2(KEY_ROWS);

   logic [15:0] ram_top_ff;
   logic        colour_board_ff;
   logic [7:0]  bank_ff, bank_in;
   logic [7:0]  strobe_ff, strobe_in;
   logic [7:0]  key_rows_ff [KEY_ROWS];
   logic [7:0]  key_mod_ff, key_mod_in;
   logic        break_ff, break_in;
   logic [7:0]  fg_ff, fg_in;
   logic [7:0]  bg_ff, bg_in;
   logic        cwe_ff, cwe_in;
   logic        reverse_ff, reverse_in;
   logic [7:0]  mode_ff, mode_in;

   logic [15:0] a;
   logic [7:0]  x;
   logic        in_io;
   logic [2:0]  bank_bit;
   logic        mapped_ram;
   logic        is_rd, is_wr;
   logic [15:0] colour_off;

   always_comb begin
      a          = req.address;
      x          = req.write_data;
      in_io      = a inside {[ADDR_IO_LO:ADDR_IO_HI]};
      is_rd      = req.command == CMD_READ;
      is_wr      = req.command == CMD_WRITE;
      colour_off = a - ADDR_COLOUR_LO;

      if (a inside {[ADDR_BANK2_LO:ADDR_BANK2_HI]}) begin
         bank_bit = BANK_F000;
      end else if (a inside {[ADDR_BANK1_LO:ADDR_BANK1_HI]}) begin
         bank_bit = BANK_E000;
      end else if (a inside {[ADDR_BANK0_LO:ADDR_BANK0_HI]}) begin
         bank_bit = BANK_B000;
      end else begin
         bank_bit = BANK_NONE;
      end
      mapped_ram = (bank_bit == BANK_NONE) || ((bank_ff[2:0] & bank_bit) != BANK_NONE);

      bank_in    = bank_ff;
      strobe_in  = strobe_ff;
      key_mod_in = key_mod_ff;
      break_in   = break_ff;
      fg_in      = fg_ff;
      bg_in      = bg_ff;
      cwe_in     = cwe_ff;
      reverse_in = reverse_ff;
      mode_in    = mode_ff;

      stage = '0;
      stage.is_mem  = is_rd && !in_io;
      stage.sel_rom = !mapped_ram;

      ram_acc.en    = accept && !in_io && mapped_ram &&
                      (is_rd || (is_wr && (a <= ram_top_ff)));
      ram_acc.we    = is_wr;
      ram_acc.addr  = a;
      ram_acc.wdata = x;

      rom_acc.en    = accept && ((is_rd && !in_io && !mapped_ram) ||
                                 (req.command == CMD_ROM_LOAD));
      rom_acc.we    = req.command == CMD_ROM_LOAD;
      rom_acc.addr  = a;
      rom_acc.wdata = x;

      case (req.command)
         CMD_READ: begin
            if (in_io) begin
               case (a)
                  IO_TAPE_STOP: begin
                     stage.tape_stop = 1'b1;
                     stage.io_byte   = 8'h01;
                  end
                  IO_TAPE_START: begin
                     stage.tape_start = 1'b1;
                     stage.io_byte    = 8'h01;
                  end
                  IO_TAPE:  stage.io_byte = req.tape_in_level;
                  IO_KEY:   stage.io_byte = key_mod_ff | key_rows_ff[strobe_ff[KEY_AW-1:0]];
                  IO_ID_FF: stage.io_byte = 8'hff;
                  IO_ID_80: stage.io_byte = 8'h80;
                  IO_BANK:  stage.io_byte = bank_ff;
                  default:  stage.io_byte = 8'h00;
               endcase
            end
         end
         CMD_WRITE: begin
            if (in_io) begin
               case (a)
                  IO_FOREGROUND: if (colour_board_ff) fg_in = x;
                  IO_BACKGROUND: if (colour_board_ff) bg_in = x;
                  IO_COLOUR_WE:  if (colour_board_ff) cwe_in = x[0];
                  IO_REVERSE:    reverse_in = x[7];
                  IO_TAPE: begin
                     stage.tape_out_valid = 1'b1;
                     stage.tape_out_data  = x;
                  end
                  IO_KEY: begin
                     strobe_in = x;
                     if (break_ff && x[7]) begin
                        break_in          = 1'b0;
                        stage.nmi_request = 1'b1;
                     end
                  end
                  IO_BANK:  bank_in = x;
                  IO_MODE:  mode_in = x & MODE_MASK;
                  default: ;
               endcase
            end else if (colour_board_ff && cwe_ff &&
                         (a inside {[ADDR_COLOUR_LO:ADDR_COLOUR_HI]})) begin
               stage.colour_write_valid = 1'b1;
               stage.colour_index       = colour_off[9:0];
               stage.colour_value       = fg_ff;
            end
         end
         CMD_KEY_ROW: key_mod_in = req.key_modifiers;
         CMD_BREAK:   break_in   = 1'b1;
         default: ;
      endcase

      stage.reverse_video     = reverse_in;
      stage.gfx_mode          = mode_in;
      stage.background_colour = bg_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ram_top_ff      <= 16'hffff;
         colour_board_ff <= 1'b0;
         bank_ff         <= '0;
         strobe_ff       <= '0;
         key_mod_ff      <= '0;
         break_ff        <= 1'b0;
         fg_ff           <= '0;
         bg_ff           <= '0;
         cwe_ff          <= 1'b0;
         reverse_ff      <= 1'b0;
         mode_ff         <= '0;
         for (int i = 0; i < KEY_ROWS; i++) begin
            key_rows_ff[i] <= '0;
         end
      end else begin
         if (csr_wr) begin
            case (csr_index)
               CSR_RAM_TOP:      ram_top_ff      <= csr_data;
               CSR_COLOUR_BOARD: colour_board_ff <= csr_data[0];
               default: ;
            endcase
         end
         if (accept) begin
            bank_ff    <= bank_in;
            strobe_ff  <= strobe_in;
            key_mod_ff <= key_mod_in;
            break_ff   <= break_in;
            fg_ff      <= fg_in;
            bg_ff      <= bg_in;
            cwe_ff     <= cwe_in;
            reverse_ff <= reverse_in;
            mode_ff    <= mode_in;
            if (req.command == CMD_KEY_ROW) begin
               key_rows_ff[req.key_row_index[KEY_AW-1:0]] <= req.key_row_bits;
            end
         end
      end
   end

endmodule

### src/memory_map_io_decoder.sv
// A word is registered into s1 at accept, then into rsp (raising rsp_tvalid) once rsp is free.
// Throughput: one word per cycle unless rsp stalls; RAM/ROM are addressed in the accept cycle,
// their data used as the word leaves s1. I/O, bank and key state update at accept, so
// following words see them at once. Reset: synchronous; a clearing pass then zeroes main RAM
// (RAM_DEPTH, 65536 entries) one entry a cycle while req_tready stays low; csr writes still taken.
module memory_map_io_decoder import mmio_pkg::*; #(
   parameter int unsigned RAM_DEPTH = RAM_DEPTH_DEF,
   parameter int unsigned ROM_DEPTH = ROM_DEPTH_DEF,
   parameter int unsigned KEY_ROWS  = KEY_ROWS_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   // address, write_data, tape_in_level, key_row_index, key_row_bits, key_modifiers
   input  logic [REQ_TDATA_W-1:0] req_tdata,
   // command
   input  logic [2:0]             req_tuser,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   // read_data, tape_stop, tape_start, tape_out_valid, tape_out_data, nmi_request,
   // colour_write_valid, colour_index, colour_value, reverse_video, gfx_mode,
   // background_colour
   output logic [RSP_TDATA_W-1:0] rsp_tdata,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_IDX_W-1:0]   csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_data
);

   localparam int unsigned RAM_AW = $clog2(RAM_DEPTH);
   localparam int unsigned ROM_AW = $clog2(ROM_DEPTH);

   bus_req_type req;
   mem_acc_type ram_acc, rom_acc;
   stage_type   stage;
   logic        accept;

   logic              clear_busy_ff, clear_busy_in;
   logic [RAM_AW-1:0] clear_addr_ff, clear_addr_in;

   logic              ram_en, ram_we;
   logic [RAM_AW-1:0] ram_addr;
   logic [7:0]        ram_wdata, ram_q, rom_q;

   logic      s1_valid_ff, s1_valid_in;
   stage_type s1_ff;
   logic      rsp_valid_ff, rsp_valid_in;
   logic [RSP_TDATA_W-1:0] rsp_data_ff;
   logic      rsp_free, s1_adv;
   logic [7:0] read_byte;

   assign req.command       = req_tuser;
   assign req.address       = req_tdata[15:0];
   assign req.write_data    = req_tdata[23:16];
   assign req.tape_in_level = req_tdata[31:24];
   assign req.key_row_index = req_tdata[35:32];
   assign req.key_row_bits  = req_tdata[43:36];
   assign req.key_modifiers = req_tdata[51:44];

   assign csr_ready  = 1'b1;
   assign rsp_free   = !rsp_valid_ff || rsp_tready;
   assign s1_adv     = s1_valid_ff && rsp_free;
   assign req_tready = !clear_busy_ff && (!s1_valid_ff || rsp_free);
   assign accept     = req_tvalid && req_tready;

   mmio_ctrl #(
      .KEY_ROWS (KEY_ROWS)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .csr_wr    (csr_valid && csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .accept    (accept),
      .req       (req),
      .ram_acc   (ram_acc),
      .rom_acc   (rom_acc),
      .stage     (stage)
   );

   always_comb begin
      clear_busy_in = clear_busy_ff;
      clear_addr_in = clear_addr_ff;
      if (clear_busy_ff) begin
         clear_addr_in = clear_addr_ff + 1'b1;
         if (clear_addr_ff == RAM_AW'(RAM_DEPTH - 1)) begin
            clear_busy_in = 1'b0;
         end
      end
      if (clear_busy_ff) begin
         ram_en    = 1'b1;
         ram_we    = 1'b1;
         ram_addr  = clear_addr_ff;
         ram_wdata = '0;
      end else begin
         ram_en    = ram_acc.en;
         ram_we    = ram_acc.we;
         ram_addr  = ram_acc.addr[RAM_AW-1:0];
         ram_wdata = ram_acc.wdata;
      end
   end

   mmio_ram #(
      .WIDTH (8),
      .DEPTH (RAM_DEPTH)
   ) u_main_ram (
      .clock (clock),
      .en    (ram_en),
      .we    (ram_we),
      .addr  (ram_addr),
      .wdata (ram_wdata),
      .rdata (ram_q)
   );

   mmio_ram #(
      .WIDTH (8),
      .DEPTH (ROM_DEPTH)
   ) u_rom (
      .clock (clock),
      .en    (rom_acc.en),
      .we    (rom_acc.we),
      .addr  (rom_acc.addr[ROM_AW-1:0]),
      .wdata (rom_acc.wdata),
      .rdata (rom_q)
   );

   always_comb begin
      s1_valid_in  = accept ? 1'b1 : (s1_adv ? 1'b0 : s1_valid_ff);
      rsp_valid_in = s1_adv ? 1'b1 : (rsp_tready ? 1'b0 : rsp_valid_ff);
      if (s1_ff.is_mem) begin
         read_byte = s1_ff.sel_rom ? rom_q : ram_q;
      end else begin
         read_byte = s1_ff.io_byte;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clear_busy_ff <= 1'b1;
         clear_addr_ff <= '0;
         s1_valid_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         clear_busy_ff <= clear_busy_in;
         clear_addr_ff <= clear_addr_in;
         s1_valid_ff   <= s1_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_ff <= stage;
      end
      if (s1_adv) begin
         rsp_data_ff <= {s1_ff.background_colour, s1_ff.gfx_mode, s1_ff.reverse_video,
                         s1_ff.colour_value, s1_ff.colour_index, s1_ff.colour_write_valid,
                         s1_ff.nmi_request, s1_ff.tape_out_data, s1_ff.tape_out_valid,
                         s1_ff.tape_start, s1_ff.tape_stop, read_byte};
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

### src/mmio_checker.sv
`include "assert_macros.svh"

module mmio_checker import mmio_pkg::*; (
   input logic                   clock,
   input logic                   reset,
   input logic                   req_tready,
   input logic                   rsp_tvalid,
   input logic                   rsp_tready,
   input logic [RSP_TDATA_W-1:0] rsp_tdata
);

   `MMIO_ASSERT_ALWAYS(a_reset_idle, reset |=> !rsp_tvalid && !req_tready, "rsp or req active after reset")
   `MMIO_ASSERT(a_rsp_hold, rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata), "stalled rsp word changed")
   `MMIO_ASSERT(a_colour_zero, rsp_tvalid && !rsp_tdata[20] |-> rsp_tdata[38:21] == 18'd0, "colour fields set without update")
   `MMIO_ASSERT(a_tape_zero, rsp_tvalid && !rsp_tdata[10] |-> rsp_tdata[18:11] == 8'd0, "tape data set without tape write")
   `MMIO_ASSERT(a_mode_mask, rsp_tvalid |-> (rsp_tdata[47:40] & ~MODE_MASK) == 8'd0, "graphics mode has bits outside mask")

endmodule

bind memory_map_io_decoder mmio_checker u_mmio_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

### dv/tb_memory_map_io_decoder.sv
module tb_memory_map_io_decoder;
   timeunit 1ns;
   timeprecision 1ps;
   import mmio_pkg::*;

   localparam int unsigned CLK_PERIOD     = 12;
   localparam int unsigned TIMEOUT_CYCLES = 1_000_000;
   localparam int unsigned RANDOM_PER_SET = 95;

   localparam logic [15:0] IO_REGS [0:11] = '{
      IO_FOREGROUND, IO_BACKGROUND, IO_COLOUR_WE, IO_TAPE_STOP, IO_TAPE_START, IO_REVERSE,
      IO_TAPE, IO_KEY, IO_ID_FF, IO_ID_80, IO_BANK, IO_MODE
   };

   // packed from the top bit down, so read_data sits in the lowest byte
   typedef struct packed {
      logic [7:0] background_colour;
      logic [7:0] gfx_mode;
      logic       reverse_video;
      logic [7:0] colour_value;
      logic [9:0] colour_index;
      logic       colour_write_valid;
      logic       nmi_request;
      logic [7:0] tape_out_data;
      logic       tape_out_valid;
      logic       tape_start;
      logic       tape_stop;
      logic [7:0] read_data;
   } bus_result_type;

   logic                   clock;
   logic                   reset;
   logic                   req_tvalid;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata;
   logic [2:0]             req_tuser;
   logic                   rsp_tvalid;
   logic                   rsp_tready;
   logic [RSP_TDATA_W-1:0] rsp_tdata;
   logic                   csr_valid;
   logic                   csr_ready;
   logic [CSR_IDX_W-1:0]   csr_index;
   logic [CSR_DATA_W-1:0]  csr_data;

   memory_map_io_decoder uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always #(CLK_PERIOD / 2.0) clock = ~clock;

   // predicted machine state
   logic [7:0]  ram_image [0:RAM_DEPTH_DEF-1];
   logic [7:0]  rom_image [0:ROM_DEPTH_DEF-1];
   logic [7:0]  key_matrix [0:KEY_ROWS_DEF-1];
   logic [7:0]  bank_reg, strobe_reg, key_mod_reg, fg_reg, bg_reg, mode_reg;
   logic        brk_pending, cwe_reg, rev_reg;
   logic [15:0] ram_top_cfg;
   logic        colour_board_cfg;

   // generator-side view, kept in step with the word order
   logic [7:0]  gen_bank;
   bit          rom_loaded [0:ROM_DEPTH_DEF-1];
   logic [15:0] recent_addr [0:7];
   int unsigned recent_ptr;

   bus_req_type    access_queue [$];
   bus_result_type bus_results_due [$];
   bus_req_type    req_word;
   bit             req_taken;
   int unsigned    req_pause, rsp_stall;
   bit             req_steady, rsp_steady;

   int unsigned words_queued, words_in, words_checked, fail_count;
   int unsigned n_reads, n_writes, n_colour, n_nmi, n_tape_out;

   function automatic logic [2:0] region_bank_bit(logic [15:0] a);
      if (a >= ADDR_BANK2_LO) return BANK_F000;
      if (a >= ADDR_BANK1_LO && a <= ADDR_BANK1_HI) return BANK_E000;
      if (a >= ADDR_BANK0_LO && a <= ADDR_BANK0_HI) return BANK_B000;
      return BANK_NONE;
   endfunction

   function automatic logic shows_rom(logic [15:0] a, logic [7:0] bank);
      logic [2:0] b;
      b = region_bank_bit(a);
      return (b != BANK_NONE) && ((bank[2:0] & b) == BANK_NONE);
   endfunction

   function automatic logic in_io(logic [15:0] a);
      return a >= ADDR_IO_LO && a <= ADDR_IO_HI;
   endfunction

   function automatic bus_result_type decode_access(bus_req_type w);
      bus_result_type r;
      logic [15:0] a;
      logic [7:0]  d;
      r = '0;
      a = w.address;
      d = w.write_data;
      case (w.command)
         CMD_READ: begin
            if (!in_io(a)) begin
               r.read_data = shows_rom(a, bank_reg) ? rom_image[a[14:0]] : ram_image[a];
            end else begin
               case (a)
                  IO_TAPE_STOP: begin
                     r.tape_stop = 1'b1;
                     r.read_data = 8'h01;
                  end
                  IO_TAPE_START: begin
                     r.tape_start = 1'b1;
                     r.read_data = 8'h01;
                  end
                  IO_TAPE:  r.read_data = w.tape_in_level;
                  IO_KEY:   r.read_data = key_mod_reg | key_matrix[strobe_reg[3:0]];
                  IO_ID_FF: r.read_data = 8'hff;
                  IO_ID_80: r.read_data = 8'h80;
                  IO_BANK:  r.read_data = bank_reg;
                  default:  r.read_data = 8'h00;
               endcase
            end
         end
         CMD_WRITE: begin
            if (a < ADDR_BANK0_LO) begin
               if (a <= ram_top_cfg) ram_image[a] = d;
               if (colour_board_cfg && cwe_reg && a >= ADDR_COLOUR_LO && a <= ADDR_COLOUR_HI) begin
                  r.colour_write_valid = 1'b1;
                  r.colour_index = 10'(a - ADDR_COLOUR_LO);
                  r.colour_value = fg_reg;
               end
            end else if (!in_io(a)) begin
               if (a <= ram_top_cfg && !shows_rom(a, bank_reg)) ram_image[a] = d;
            end else begin
               case (a)
                  IO_FOREGROUND: if (colour_board_cfg) fg_reg = d;
                  IO_BACKGROUND: if (colour_board_cfg) bg_reg = d;
                  IO_COLOUR_WE:  if (colour_board_cfg) cwe_reg = d[0];
                  IO_REVERSE:    rev_reg = d[7];
                  IO_TAPE: begin
                     r.tape_out_valid = 1'b1;
                     r.tape_out_data = d;
                  end
                  IO_KEY: begin
                     strobe_reg = d;
                     if (brk_pending && d[7]) begin
                        brk_pending = 1'b0;
                        r.nmi_request = 1'b1;
                     end
                  end
                  IO_BANK: bank_reg = d;
                  IO_MODE: mode_reg = d & MODE_MASK;
                  default: ;
               endcase
            end
         end
         CMD_KEY_ROW: begin
            key_matrix[w.key_row_index] = w.key_row_bits;
            key_mod_reg = w.key_modifiers;
         end
         CMD_BREAK:    brk_pending = 1'b1;
         CMD_ROM_LOAD: rom_image[a[14:0]] = d;
         default: ;
      endcase
      r.reverse_video = rev_reg;
      r.gfx_mode = mode_reg;
      r.background_colour = bg_reg;
      return r;
   endfunction

   function automatic int unsigned pick_pause(bit steady);
      int unsigned r;
      if (steady) return 0;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 88) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 40);
   endfunction

   function automatic bus_req_type rand_word(logic [2:0] cmd, logic [15:0] a, logic [7:0] d);
      bus_req_type w;
      w.command = cmd;
      w.address = a;
      w.write_data = d;
      w.tape_in_level = 8'($urandom);
      w.key_row_index = 4'($urandom);
      w.key_row_bits = 8'($urandom);
      w.key_modifiers = 8'($urandom);
      return w;
   endfunction

   // never read a ROM byte that was not loaded: load it just ahead of the read
   function automatic void queue_word(bus_req_type w);
      bus_req_type fill;
      if (w.command == CMD_READ && shows_rom(w.address, gen_bank)
          && !rom_loaded[w.address[14:0]]) begin
         fill = rand_word(CMD_ROM_LOAD, w.address, 8'($urandom));
         access_queue.push_back(fill);
         rom_loaded[w.address[14:0]] = 1'b1;
         words_queued++;
      end
      access_queue.push_back(w);
      words_queued++;
      if (w.command == CMD_ROM_LOAD) rom_loaded[w.address[14:0]] = 1'b1;
      if (w.command == CMD_WRITE && w.address == IO_BANK) gen_bank = w.write_data;
      if (w.command == CMD_WRITE || w.command == CMD_ROM_LOAD) begin
         recent_addr[recent_ptr] = w.address;
         recent_ptr = (recent_ptr + 1) % 8;
      end
   endfunction

   function automatic void put(logic [2:0] cmd, logic [15:0] a, logic [7:0] d);
      queue_word(rand_word(cmd, a, d));
   endfunction

   function automatic logic [15:0] pick_address();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 20) return 16'($urandom_range(16'h0000, 16'hafff));
      if (r < 30) return 16'($urandom_range(16'h00f0, 16'h040f));
      if (r < 40) return 16'($urandom_range(ADDR_BANK0_LO, ADDR_BANK0_HI));
      if (r < 47) return 16'($urandom_range(ADDR_BANK1_LO, ADDR_BANK1_HI));
      if (r < 57) return 16'($urandom_range(ADDR_BANK2_LO, ADDR_BANK2_HI));
      if (r < 75) return IO_REGS[$urandom_range(0, 11)];
      if (r < 80) return 16'($urandom_range(ADDR_IO_LO, ADDR_IO_HI));
      if (r < 85) return 16'($urandom);
      return recent_addr[$urandom_range(0, 7)];
   endfunction

   task automatic queue_random(int unsigned count);
      int unsigned r;
      bus_req_type w;
      repeat (count) begin
         r = $urandom_range(0, 99);
         if (r < 34) w = rand_word(CMD_READ, pick_address(), 8'($urandom));
         else if (r < 68) w = rand_word(CMD_WRITE, pick_address(), 8'($urandom));
         else if (r < 76) w = rand_word(CMD_KEY_ROW, 16'($urandom), 8'($urandom));
         else if (r < 81) w = rand_word(CMD_BREAK, 16'($urandom), 8'($urandom));
         else if (r < 94) w = rand_word(CMD_ROM_LOAD, pick_address(), 8'($urandom));
         else w = rand_word(3'($urandom_range(5, 7)), 16'($urandom), 8'($urandom));
         queue_word(w);
      end
   endtask

   task automatic wait_idle();
      while (words_in != words_queued || bus_results_due.size() != 0) @(posedge clock);
   endtask

   task automatic write_reg(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] val);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      if (idx == CSR_RAM_TOP) ram_top_cfg = val;
      else colour_board_cfg = val[0];
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic report_mismatch(string what, logic [15:0] got, logic [15:0] want);
      fail_count++;
      if (fail_count <= 40)
         $display("%0t ns: word %0d %s got %h want %h", $time, words_checked, what, got, want);
   endtask

   // sender
   always @(negedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_taken) begin
         req_taken = 1'b0;
         if (req_pause > 0 || access_queue.size() == 0) begin
            if (req_pause > 0) req_pause--;
            req_tvalid <= 1'b0;
         end else begin
            req_word = access_queue.pop_front();
            req_tvalid <= 1'b1;
            req_tdata <= {4'b0, req_word.key_modifiers, req_word.key_row_bits,
                          req_word.key_row_index, req_word.tape_in_level,
                          req_word.write_data, req_word.address};
            req_tuser <= req_word.command;
            req_pause = pick_pause(req_steady);
         end
      end
   end

   // receiver backpressure
   always @(negedge clock) begin
      if (rsp_stall > 0) begin
         rsp_tready <= 1'b0;
         rsp_stall--;
      end else begin
         rsp_tready <= 1'b1;
         if ($urandom_range(0, 3) == 0) rsp_stall = pick_pause(rsp_steady);
      end
   end

   always @(posedge clock) begin
      bus_result_type got, want;
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            bus_results_due.push_back(decode_access(req_word));
            words_in++;
            req_taken = 1'b1;
            if (req_word.command == CMD_READ) n_reads++;
            if (req_word.command == CMD_WRITE) n_writes++;
            if ($urandom_range(0, 59) == 0) req_steady = !req_steady;
         end
         if (rsp_tvalid && rsp_tready) begin
            got = rsp_tdata;
            if (bus_results_due.size() == 0) begin
               report_mismatch("unexpected word", 16'(got.read_data), 16'h0);
            end else begin
               want = bus_results_due.pop_front();
               if (got.read_data !== want.read_data)
                  report_mismatch("read_data", 16'(got.read_data), 16'(want.read_data));
               if (got.tape_stop !== want.tape_stop)
                  report_mismatch("tape_stop", 16'(got.tape_stop), 16'(want.tape_stop));
               if (got.tape_start !== want.tape_start)
                  report_mismatch("tape_start", 16'(got.tape_start), 16'(want.tape_start));
               if (got.tape_out_valid !== want.tape_out_valid)
                  report_mismatch("tape_out_valid", 16'(got.tape_out_valid),
                                  16'(want.tape_out_valid));
               if (got.tape_out_data !== want.tape_out_data)
                  report_mismatch("tape_out_data", 16'(got.tape_out_data),
                                  16'(want.tape_out_data));
               if (got.nmi_request !== want.nmi_request)
                  report_mismatch("nmi_request", 16'(got.nmi_request), 16'(want.nmi_request));
               if (got.colour_write_valid !== want.colour_write_valid)
                  report_mismatch("colour_write_valid", 16'(got.colour_write_valid),
                                  16'(want.colour_write_valid));
               if (got.colour_index !== want.colour_index)
                  report_mismatch("colour_index", 16'(got.colour_index), 16'(want.colour_index));
               if (got.colour_value !== want.colour_value)
                  report_mismatch("colour_value", 16'(got.colour_value), 16'(want.colour_value));
               if (got.reverse_video !== want.reverse_video)
                  report_mismatch("reverse_video", 16'(got.reverse_video),
                                  16'(want.reverse_video));
               if (got.gfx_mode !== want.gfx_mode)
                  report_mismatch("gfx_mode", 16'(got.gfx_mode), 16'(want.gfx_mode));
               if (got.background_colour !== want.background_colour)
                  report_mismatch("background_colour", 16'(got.background_colour),
                                  16'(want.background_colour));
               if (want.colour_write_valid) n_colour++;
               if (want.nmi_request) n_nmi++;
               if (want.tape_out_valid) n_tape_out++;
            end
            words_checked++;
            if ($urandom_range(0, 59) == 0) rsp_steady = !rsp_steady;
         end
      end
   end

   initial begin
      bus_req_type w;
      clock = 1'b0;
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      req_tuser = '0;
      rsp_tready = 1'b0;
      csr_valid = 1'b0;
      csr_index = '0;
      csr_data = '0;
      for (int i = 0; i < RAM_DEPTH_DEF; i++) ram_image[i] = 8'h00;
      for (int i = 0; i < ROM_DEPTH_DEF; i++) begin
         rom_image[i] = 8'h00;
         rom_loaded[i] = 1'b0;
      end
      for (int i = 0; i < KEY_ROWS_DEF; i++) key_matrix[i] = 8'h00;
      for (int i = 0; i < 8; i++) recent_addr[i] = 16'h0000;
      {bank_reg, strobe_reg, key_mod_reg, fg_reg, bg_reg, mode_reg} = '0;
      {brk_pending, cwe_reg, rev_reg} = '0;
      ram_top_cfg = 16'hffff;
      colour_board_cfg = 1'b0;
      gen_bank = 8'h00;

      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // reset settings: plain memory map, no colour board
      put(CMD_READ, 16'h0000, 8'h00);
      put(CMD_WRITE, 16'h0000, 8'hff);
      put(CMD_READ, 16'h0000, 8'h00);
      put(CMD_ROM_LOAD, 16'hffff, 8'ha5);
      put(CMD_READ, 16'hffff, 8'h00);
      put(CMD_ROM_LOAD, 16'h3000, 8'h5a);
      put(CMD_READ, ADDR_BANK0_LO, 8'h00);
      put(CMD_WRITE, IO_BANK, 8'h07);
      put(CMD_WRITE, 16'hffff, 8'h3c);
      put(CMD_READ, 16'hffff, 8'h00);
      put(CMD_READ, IO_BANK, 8'h00);
      put(CMD_READ, IO_TAPE_STOP, 8'h00);
      put(CMD_READ, IO_TAPE_START, 8'h00);
      w = rand_word(CMD_READ, IO_TAPE, 8'h00);
      w.tape_in_level = 8'hff;
      queue_word(w);
      put(CMD_READ, IO_ID_FF, 8'h00);
      put(CMD_READ, IO_ID_80, 8'h00);
      put(CMD_READ, ADDR_IO_LO, 8'h00);
      w = rand_word(CMD_KEY_ROW, 16'h0000, 8'h00);
      w.key_row_index = 4'hf;
      w.key_row_bits = 8'hff;
      w.key_modifiers = 8'h00;
      queue_word(w);
      put(CMD_WRITE, IO_KEY, 8'h0f);
      put(CMD_READ, IO_KEY, 8'h00);
      put(CMD_BREAK, 16'h0000, 8'h00);
      put(CMD_WRITE, IO_KEY, 8'h80);
      put(CMD_WRITE, IO_KEY, 8'h80);
      put(CMD_WRITE, IO_REVERSE, 8'h80);
      put(CMD_WRITE, IO_MODE, 8'hff);
      put(CMD_WRITE, IO_TAPE, 8'ha5);
      put(CMD_WRITE, IO_COLOUR_WE, 8'h01);
      put(CMD_WRITE, ADDR_COLOUR_LO, 8'h33);
      put(3'd7, 16'hffff, 8'hff);
      put(CMD_WRITE, IO_BANK, 8'h00);
      queue_random(RANDOM_PER_SET);
      wait_idle();

      write_reg(CSR_COLOUR_BOARD, 16'h0001);
      put(CMD_WRITE, IO_FOREGROUND, 8'h5a);
      put(CMD_WRITE, IO_BACKGROUND, 8'hff);
      put(CMD_WRITE, IO_COLOUR_WE, 8'h01);
      put(CMD_WRITE, ADDR_COLOUR_LO, 8'h00);
      put(CMD_WRITE, ADDR_COLOUR_HI, 8'hff);
      put(CMD_WRITE, 16'h0400, 8'h01);
      put(CMD_WRITE, 16'h00ff, 8'h01);
      put(CMD_WRITE, IO_COLOUR_WE, 8'hfe);
      put(CMD_WRITE, ADDR_COLOUR_LO, 8'h02);
      queue_random(RANDOM_PER_SET);
      wait_idle();

      // smallest RAM: only address 0 takes writes
      write_reg(CSR_RAM_TOP, 16'h0000);
      put(CMD_WRITE, IO_COLOUR_WE, 8'h01);
      put(CMD_WRITE, 16'h0000, 8'h77);
      put(CMD_WRITE, 16'h0001, 8'h88);
      put(CMD_READ, 16'h0000, 8'h00);
      put(CMD_READ, 16'h0001, 8'h00);
      put(CMD_WRITE, 16'h0200, 8'h99);
      put(CMD_READ, 16'h0200, 8'h00);
      put(CMD_WRITE, IO_BANK, 8'hff);
      put(CMD_WRITE, ADDR_BANK2_LO, 8'h11);
      put(CMD_READ, ADDR_BANK2_LO, 8'h00);
      queue_random(RANDOM_PER_SET);
      wait_idle();

      write_reg(CSR_RAM_TOP, 16'hafff);
      write_reg(CSR_COLOUR_BOARD, 16'h0000);
      queue_random(RANDOM_PER_SET);
      wait_idle();

      write_reg(CSR_RAM_TOP, 16'($urandom_range(16'h0400, 16'hefff)));
      write_reg(CSR_COLOUR_BOARD, 16'h0001);
      queue_random(RANDOM_PER_SET);
      wait_idle();

      write_reg(CSR_RAM_TOP, 16'hffff);
      queue_random(RANDOM_PER_SET);
      wait_idle();

      repeat (8) @(posedge clock);
      $display("checked %0d words (%0d reads, %0d writes) over six register settings",
               words_checked, n_reads, n_writes);
      $display("events seen: %0d colour-map updates, %0d NMI requests, %0d tape bytes out",
               n_colour, n_nmi, n_tape_out);
      if (fail_count == 0)
         $display("memory_map_io_decoder: match");
      else
         $display("memory_map_io_decoder: mismatch");
      $finish;
   end

   // covers the RAM clearing pass after reset plus stalls on both sides
   initial begin
      repeat (TIMEOUT_CYCLES) @(posedge clock);
      $display("timeout with %0d words outstanding", bus_results_due.size());
      $display("memory_map_io_decoder: mismatch");
      $finish;
   end

endmodule

### files.f
+incdir+src
src/mmio_pkg.sv
src/mmio_ram.sv
src/mmio_ctrl.sv
src/memory_map_io_decoder.sv
src/mmio_checker.sv
dv/tb_memory_map_io_decoder.sv
